// ----- hw/rtl/hwu_pkg.sv -----
package hwu_pkg;

    // Fixed-point constants of the exponential.
    localparam logic [31:0] ONE_Q31    = 32'h8000_0000;
    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [3:0]  HORNER_DEG = 4'd12;
    localparam int          SUM_W      = 44;
    localparam int          MAX_ITEMS  = 4096;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Register indexes.
    localparam logic REG_LOSS_FLOOR = 1'b0;
    localparam logic REG_LEARN_RATE = 1'b1;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic        sat_one;
        logic [31:0] excess;
        logic        last;
    } hwu_item_t;

    // Reciprocal floor(2^34 / k) for the Horner divisors 1 to 12.
    function automatic logic [34:0] hwu_recip(input logic [3:0] k);
        logic [34:0] r;
        unique case (k)
            4'd1:    r = 35'd17179869184;
            4'd2:    r = 35'd8589934592;
            4'd3:    r = 35'd5726623061;
            4'd4:    r = 35'd4294967296;
            4'd5:    r = 35'd3435973836;
            4'd6:    r = 35'd2863311530;
            4'd7:    r = 35'd2454267026;
            4'd8:    r = 35'd2147483648;
            4'd9:    r = 35'd1908874353;
            4'd10:   r = 35'd1717986918;
            4'd11:   r = 35'd1561806289;
            4'd12:   r = 35'd1431655765;
            default: r = 35'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/hwu_front.sv -----
module hwu_front
    import hwu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       loss,
    input  logic              last,
    input  logic [31:0]       loss_floor,
    output logic              q_valid,
    output hwu_item_t         q_item,
    input  logic              q_pop
);

    hwu_item_t   fifo_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic [32:0] excess;
    hwu_item_t   item_in;
    logic        push;

    // Classify: the excess is exact in 33 bits; at or below zero saturates.
    assign excess = {loss[31], loss} - {loss_floor[31], loss_floor};
    assign item_in.sat_one = excess[32] | (excess == 33'd0);
    assign item_in.excess  = excess[31:0];
    assign item_in.last    = last;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid & in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_mem[rd_ptr_reg];

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ----- hw/rtl/hwu_back.sv -----
module hwu_back
    import hwu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  hwu_item_t         q_item,
    output logic              q_pop,
    input  logic [23:0]       learn_rate,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       weight,
    output logic [SUM_W-1:0]  total,
    output logic              done_res
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MX   = 10'b00_0000_0010,
        S_MY   = 10'b00_0000_0100,
        S_MU   = 10'b00_0000_1000,
        S_HA   = 10'b00_0001_0000,
        S_HB   = 10'b00_0010_0000,
        S_HC   = 10'b00_0100_0000,
        S_FIN  = 10'b00_1000_0000,
        S_ACC  = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        excess_reg;
    logic               last_reg;
    logic [55:0]        x_reg;
    logic [5:0]         n_reg;
    logic [31:0]        f_reg;
    logic [31:0]        u_reg;
    logic [32:0]        p_reg;
    logic [3:0]         k_reg;
    logic [31:0]        v_reg;
    logic [31:0]        q0_reg;
    logic [31:0]        w_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [31:0]        weight_reg;
    logic [SUM_W-1:0]   total_reg;
    logic               done_reg;
    logic               out_valid_reg;

    logic [63:0]        y_prod;
    logic [63:0]        u_prod;
    logic [64:0]        up_prod;
    logic [66:0]        q_prod;
    logic [35:0]        qk;
    logic [35:0]        rem;
    logic [31:0]        q_fix;
    logic [33:0]        fin_sum;
    logic [33:0]        fin_shift;
    logic [SUM_W:0]     acc_sum;

    // One multiplier per state; each product is registered.
    assign y_prod    = {31'd0, x_reg[36:4]} * {33'd0, LOG2E_Q30};
    assign u_prod    = {32'd0, f_reg} * {32'd0, LN2_Q32};
    assign up_prod   = {33'd0, u_reg} * {32'd0, p_reg};
    assign q_prod    = {35'd0, v_reg} * {32'd0, hwu_recip(k_reg)};
    assign qk        = {4'd0, q0_reg} * {32'd0, k_reg};
    assign rem       = {4'd0, v_reg} - qk;
    assign q_fix     = (rem >= {32'd0, k_reg}) ? q0_reg + 32'd1 : q0_reg;
    assign fin_sum   = {1'b0, p_reg} + (34'd1 << n_reg);
    assign fin_shift = fin_sum >> (n_reg + 6'd1);
    assign acc_sum   = {1'b0, sum_reg} + {13'd0, w_reg};

    assign q_pop     = (state_reg == S_IDLE) & q_valid;
    assign out_valid = out_valid_reg;
    assign weight    = weight_reg;
    assign total     = total_reg;
    assign done_res  = done_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = q_item.sat_one ? S_ACC : S_MX;
            S_MX:   state_next = S_MY;
            S_MY:   state_next = (x_reg >= (56'd32 << 32)) ? S_ACC : S_MU;
            S_MU:   state_next = S_HA;
            S_HA:   state_next = S_HB;
            S_HB:   state_next = S_HC;
            S_HC:   state_next = (k_reg == 4'd1) ? S_FIN : S_HA;
            S_FIN:  state_next = S_ACC;
            S_ACC:  state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ACC)
            begin
                out_valid_reg <= 1'b1;
                sum_reg <= last_reg ? '0 :
                           (acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0]);
            end
            else if (state_reg == S_OUT && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                excess_reg <= q_item.excess;
                last_reg   <= q_item.last;
                w_reg      <= ONE_Q31;
            end
            S_MX:  x_reg <= {24'd0, excess_reg} * {32'd0, learn_rate};
            S_MY:
            begin
                n_reg <= y_prod[63:58];
                f_reg <= y_prod[57:26];
                w_reg <= 32'd0;
            end
            S_MU:
            begin
                u_reg <= u_prod[63:32];
                p_reg <= ONE_Q32;
                k_reg <= HORNER_DEG;
            end
            S_HA:  v_reg  <= up_prod[63:32];
            S_HB:  q0_reg <= q_prod[65:34];
            S_HC:
            begin
                p_reg <= ONE_Q32 - {1'b0, q_fix};
                k_reg <= k_reg - 4'd1;
            end
            S_FIN:
            begin
                if (n_reg >= 6'd33)
                    w_reg <= 32'd0;
                else if (fin_shift > {2'd0, ONE_Q31})
                    w_reg <= ONE_Q31;
                else
                    w_reg <= fin_shift[31:0];
            end
            S_ACC:
            begin
                weight_reg <= w_reg;
                total_reg  <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
                done_reg   <= last_reg;
            end
            S_OUT: ;
            default: ;
        endcase
    end

endmodule

// ----- hw/rtl/hedge_weight_update_top.sv -----
// Channel | Signals                                   | Beat
// in      | in_valid, in_ready, loss, last            | one expert loss
// out     | out_valid, out_ready, weight, total, done_res | one weight and sum
// cfg     | psel, penable, pwrite, paddr, pwdata, prdata, pready | register access
// Each loss beat passes through the queue into the back end, which takes a short path
// when it is at or below the loss floor or when the exponent reaches 32 or more, and
// otherwise runs the twelve steps of the Horner loop, each through S_HA, S_HB and S_HC.
// Reset clears the queue, the sequencer and the running sum; no clearing pass.
// A two-beat queue keeps accepting losses, until it is full, while the exponential unit or output stalls.
module hedge_weight_update_top
    import hwu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       loss,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       weight,
    output logic [SUM_W-1:0]  total,
    output logic              done_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0] loss_floor_reg;
    logic [23:0] learn_rate_reg;
    logic        q_valid;
    logic        q_pop;
    hwu_item_t   q_item;

    assign pready = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_floor_reg <= 32'd0;
            learn_rate_reg <= 24'd65536;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_LOSS_FLOOR)
                loss_floor_reg <= pwdata;
            else
                learn_rate_reg <= pwdata[23:0];
        end
    end

    // Register reads.
    assign prdata = (paddr[2] == REG_LEARN_RATE) ? {8'd0, learn_rate_reg} : loss_floor_reg;

    hwu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .loss       (loss),
        .last       (last),
        .loss_floor (loss_floor_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    hwu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .learn_rate (learn_rate_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .weight     (weight),
        .total      (total),
        .done_res   (done_res)
    );

endmodule

// ----- hw/rtl/hwu_checker.sv -----
module hwu_checker
    import hwu_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [31:0]       weight,
    input logic [SUM_W-1:0]  total,
    input logic              pready
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // The weight never exceeds 1.0.
    a_weight_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight <= ONE_Q31)
        else $error("weight above 1.0");

    // The running sum includes the weight of this beat.
    a_total_ge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> total >= {12'd0, weight})
        else $error("total below weight");

    // The register port never waits.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind hedge_weight_update_top hwu_checker u_hwu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .weight    (weight),
    .total     (total),
    .pready    (pready)
);

// ----- tb/hedge_weight_update_checker.sv -----
`timescale 1ns / 1ps

module hedge_weight_update_checker
    import hwu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [31:0]       loss,
    input  logic              last,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [31:0]       weight,
    input  logic [SUM_W-1:0]  total,
    input  logic              done_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output int                fail_count,
    output int                pending_count
);

    typedef struct {
        logic [31:0]      weight;
        logic [SUM_W-1:0] total;
        logic             done_res;
    } weight_beat_t;

    weight_beat_t expected_weights[$];
    logic signed [31:0] loss_floor_r;
    logic [23:0]        learn_rate_r;
    logic [SUM_W-1:0]   weight_sum_r;

    // Computes exp(-rate * excess) in Q1.31 with the truncating Horner scheme.
    function automatic logic [31:0] hedge_exp(input logic signed [31:0] l);
        logic signed [33:0] excess;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] f;
        logic [63:0] u;
        logic [63:0] p;
        logic [63:0] n;
        logic [63:0] w;
        logic [127:0] wide;
        excess = 34'(l) - 34'(loss_floor_r);
        if (excess <= 0)
            return ONE_Q31;
        x = 64'(excess) * 64'(learn_rate_r);
        if (x >= (64'd32 << 32))
            return 32'd0;
        wide = 128'(x >> 4) * 128'(LOG2E_Q30);
        y = 64'(wide >> 26);
        n = y >> 32;
        f = y & 64'hFFFF_FFFF;
        u = (f * 64'(LN2_Q32)) >> 32;
        p = 64'h1_0000_0000;
        for (int k = 12; k >= 1; k--)
        begin
            wide = 128'(u) * 128'(p);
            p = 64'h1_0000_0000 - 64'(wide >> 32) / 64'(k);
        end
        if (n + 1 >= 34)
            return 32'd0;
        w = (p + (64'd1 << n)) >> (n + 1);
        if (w > 64'(ONE_Q31))
            w = 64'(ONE_Q31);
        return w[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_floor_r  <= '0;
            learn_rate_r  <= 24'd65536;
            weight_sum_r  <= '0;
            fail_count    <= 0;
            pending_count <= 0;
            expected_weights.delete();
        end
        else
        begin
            weight_beat_t e;
            logic [SUM_W:0] s;
            // Register writes.
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_LOSS_FLOOR && paddr[1:0] == 2'b00)
                    loss_floor_r <= pwdata;
                else if (paddr[2] == REG_LEARN_RATE && paddr[1:0] == 2'b00)
                    learn_rate_r <= pwdata[23:0];
            end
            // Accepted loss beats produce one expectation each.
            if (in_valid && in_ready)
            begin
                e.weight = hedge_exp(loss);
                s = {1'b0, weight_sum_r} + (SUM_W + 1)'(e.weight);
                e.total = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
                e.done_res = last;
                weight_sum_r <= last ? '0 : e.total;
                expected_weights.push_back(e);
            end
            // Compare each result beat with the oldest expectation.
            if (out_valid && out_ready)
            begin
                if (expected_weights.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result beat: weight %h total %h", weight, total);
                end
                else
                begin
                    e = expected_weights.pop_front();
                    if (e.weight !== weight || e.total !== total || e.done_res !== done_res)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: exp %h %h %b got %h %h %b",
                                e.weight, e.total, e.done_res, weight, total, done_res);
                    end
                end
            end
            pending_count <= expected_weights.size();
        end
    end

endmodule

// ----- tb/hedge_weight_update_top_test.sv -----
`timescale 1ns / 1ps

module hedge_weight_update_top_test;
    import hwu_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [31:0]      loss = '0;
    logic             last = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [31:0]      weight;
    logic [SUM_W-1:0] total;
    logic             done_res;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    int               fail_count;
    int               pending_count;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               hold_cycles = 0;
    longint           cycle_count = 0;

    hedge_weight_update_top dut (.*);

    hedge_weight_update_checker checker_i (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Drives one loss beat and returns at the falling edge after acceptance.
    // Valid is dropped only while the sender idles or the stream drains.
    task automatic send_loss(input logic [31:0] l, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        loss     <= l;
        last     <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Losses spread around a reference loss, mostly the loss floor, so that weights span 1.0 down to 0.
    function automatic logic [31:0] pick_loss(input logic [31:0] ref_loss);
        case ($urandom_range(4))
            0: return $urandom;
            1: return ref_loss - $urandom_range(65536);
            default: return ref_loss + $urandom_range(1 << ($urandom_range(22)));
        endcase
    endfunction

    task automatic random_phase(input int beats, input logic [31:0] ref_loss);
        for (int i = 0; i < beats; i++)
            send_loss(pick_loss(ref_loss), $urandom_range(7) == 0);
        send_loss(pick_loss(ref_loss), 1'b1);
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset settings, loss extremes, boundaries and zero rate.
        send_loss(32'h0000_0000, 1'b0);
        send_loss(32'h8000_0000, 1'b0);
        send_loss(32'h7FFF_FFFF, 1'b0);
        send_loss(32'hFFFF_FFFF, 1'b0);
        send_loss(32'h0000_0001, 1'b0);
        send_loss(32'h0001_0000, 1'b0);
        send_loss(32'h000B_1720, 1'b0);
        send_loss(32'h0016_2E43, 1'b0);
        send_loss(32'h0020_0000, 1'b1);
        wait_drain();
        write_reg(REG_LEARN_RATE, 32'hFF00_0000);
        send_loss(32'h0005_0000, 1'b0);
        send_loss(32'h7FFF_FFFF, 1'b1);
        wait_drain();
        write_reg(REG_LEARN_RATE, 32'h00FF_FFFF);
        write_reg(REG_LOSS_FLOOR, 32'h8000_0000);
        send_loss(32'h8000_0000, 1'b0);
        send_loss(32'h8000_0001, 1'b0);
        send_loss(32'h7FFF_FFFF, 1'b1);
        wait_drain();
        write_reg(REG_LOSS_FLOOR, 32'h7FFF_FFFF);
        write_reg(REG_LEARN_RATE, 32'h0000_0001);
        send_loss(32'h8000_0000, 1'b0);
        send_loss(32'h7FFF_FFFF, 1'b1);
        wait_drain();

        // Long vector, held off at the output so the queue fills up.
        write_reg(REG_LOSS_FLOOR, 32'h0000_0000);
        hold_cycles = 300;
        for (int i = 0; i < 100; i++)
            send_loss(32'h8000_0000 | $urandom_range(255), 1'b0);
        send_loss(32'h0000_0000, 1'b1);
        wait_drain();

        // Random phases: sender idles lightly, then receiver, then neither.
        send_idle_pct = 22;
        recv_idle_pct = 88;
        write_reg(REG_LOSS_FLOOR, 32'hFFF0_0000);
        write_reg(REG_LEARN_RATE, 32'h0000_4000);
        random_phase(180, 32'hFFF0_0000);
        wait_drain();
        send_idle_pct = 88;
        recv_idle_pct = 22;
        write_reg(REG_LOSS_FLOOR, 32'h0003_0000);
        write_reg(REG_LEARN_RATE, 32'h0003_0000);
        random_phase(180, 32'h0003_0000);
        wait_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_LOSS_FLOOR, $urandom);
        write_reg(REG_LEARN_RATE, $urandom_range(24'hFFFFFF));
        random_phase(180, 32'h0000_0000);
        wait_drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
